// ----- rtl/core/lmfw_pkg.sv -----
// Shared types, constants and bit functions of the LED matrix frame writer.
package lmfw_pkg;

    localparam int unsigned FRAME_ROWS = 16;
    localparam int unsigned FRAME_COLS = 64;
    localparam logic [7:0]  FIRST_CODE = 8'd33;
    localparam logic [3:0]  LAST_PRINT_STEP = 4'd8;
    localparam logic [3:0]  LAST_EMIT_WORD = 4'd15;
    localparam logic [3:0]  DIGIT_MIN = 4'd1;
    localparam logic [3:0]  DIGIT_MAX = 4'd8;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_PRINT = 2'd1,
        MODE_EMIT  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRINT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       ready;
        logic       print_we;
        logic       emit_load;
        logic       use_emit;
        logic       last;
        logic [3:0] row_sel;
        logic [5:0] shift_amt;
        logic [2:0] font_row;
    } t_ctl;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = b[k];
        end
        return r;
    endfunction

    function automatic logic [7:0] rotr1(input logic [7:0] b);
        return {b[0], b[7:1]};
    endfunction

endpackage

// ----- rtl/core/lmfw_in_if.sv -----
// Request channel into the frame writer.
interface lmfw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] symbol_code;
    logic [2:0] font_row;
    logic [7:0] font_byte;
    logic [5:0] x_pos;
    logic [3:0] y_pos;
    logic [3:0] digit;

    modport source (
        output valid, mode, symbol_code, font_row, font_byte, x_pos, y_pos, digit,
        input  ready
    );
    modport sink (
        input  valid, mode, symbol_code, font_row, font_byte, x_pos, y_pos, digit,
        output ready
    );
endinterface

// ----- rtl/core/lmfw_out_if.sv -----
// Word channel out of the frame writer.
interface lmfw_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_addr;
    logic [7:0] data_byte;
    logic       last;

    modport source (
        output valid, reg_addr, data_byte, last,
        input  ready
    );
    modport sink (
        input  valid, reg_addr, data_byte, last,
        output ready
    );
endinterface

// ----- rtl/core/led_matrix_frame_writer_unit.sv -----
// Top level of the LED matrix frame writer: frame store, font store and output register.
//
//  channel  | dir | payload                                               | handshake
//  i_in     | in  | mode symbol_code font_row font_byte x_pos y_pos digit | valid/ready
//  o_out    | out | reg_addr data_byte last                               | valid/ready
//
// Font load and frame clear are taken while the sequencer is idle and leave the input ready.
// A print holds the input off after it is taken, while the font memory
// read port gives one glyph row per cycle and the shared shifter merges it.
// An emit holds the input off until its sixteen words have gone into the output register,
// one word per cycle while that register is free; a word waits while it is full and not taken.
// Reset clears the frame at once; the font store holds nothing defined until loaded.
module led_matrix_frame_writer_unit
    import lmfw_pkg::*;
#(
    parameter int unsigned GLYPHS = 96
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lmfw_in_if.sink      i_in,
    lmfw_out_if.source   o_out
);

    localparam int unsigned G_W   = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
    localparam int unsigned FA_W  = G_W + 3;
    localparam int unsigned DEPTH = GLYPHS * 8;
    localparam logic [8:0]  GLYPHS_LIM = 9'(GLYPHS);

    t_ctl                  ctl;
    logic                  in_fire;
    logic                  out_free;
    logic [7:0]            code_off;
    logic                  glyph_ok;
    logic [G_W-1:0]        r_g;
    logic [7:0]            font_rdata;
    logic [FRAME_COLS-1:0] r_frame [FRAME_ROWS];
    logic [FRAME_COLS-1:0] new_row;
    logic [7:0]            wire_byte;
    logic                  r_out_valid;
    logic [3:0]            r_out_addr;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    logic [3:0]            r_emit_addr;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign code_off = i_in.symbol_code - FIRST_CODE;
    assign glyph_ok = (i_in.symbol_code >= FIRST_CODE) && ({1'b0, code_off} < GLYPHS_LIM);

    lmfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (t_mode'(i_in.mode)),
        .i_glyph_ok (glyph_ok),
        .i_x_pos    (i_in.x_pos),
        .i_y_pos    (i_in.y_pos),
        .i_digit    (i_in.digit),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    assign i_in.ready = ctl.ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_g         <= code_off[G_W-1:0];
            r_emit_addr <= i_in.digit;
        end
    end

    lmfw_font_mem #(
        .DEPTH (DEPTH),
        .AW    (FA_W)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (in_fire && t_mode'(i_in.mode) == MODE_LOAD && glyph_ok),
        .i_waddr ({code_off[G_W-1:0], i_in.font_row}),
        .i_wdata (i_in.font_byte),
        .i_re    (!ctl.ready && !ctl.use_emit),
        .i_raddr ({r_g, ctl.font_row}),
        .o_rdata (font_rdata)
    );

    lmfw_row_unit u_row (
        .i_use_emit   (ctl.use_emit),
        .i_row        (r_frame[ctl.row_sel]),
        .i_glyph_byte (font_rdata),
        .i_amt        (ctl.shift_amt),
        .o_row        (new_row),
        .o_byte       (wire_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < FRAME_ROWS; r++) begin
                r_frame[r] <= '0;
            end
        end else if (in_fire && t_mode'(i_in.mode) == MODE_CLEAR) begin
            for (int r = 0; r < FRAME_ROWS; r++) begin
                r_frame[r] <= '0;
            end
        end else if (ctl.print_we) begin
            r_frame[ctl.row_sel] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit_load) begin
            r_out_addr <= r_emit_addr;
            r_out_byte <= wire_byte;
            r_out_last <= ctl.last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.reg_addr  = r_out_addr;
    assign o_out.data_byte = r_out_byte;
    assign o_out.last      = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit_load |-> (!r_out_valid || o_out.ready))
        else $error("emit word loaded over an untaken word");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit_load && ctl.last) |=> (ctl.ready && r_out_valid && o_out.last))
        else $error("sequencer not idle with last word held after emit");

    a_print_not_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.print_we |-> (!ctl.use_emit && !ctl.ready))
        else $error("frame row written outside a print");
`endif

endmodule

// ----- rtl/core/lmfw_font_mem.sv -----
// Glyph row store with one write port and one registered read port.
module lmfw_font_mem #(
    parameter int unsigned DEPTH = 768,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lmfw_row_unit.sv -----
// Shared 64-bit shifter: places glyph bits into a row or picks one wire byte.
module lmfw_row_unit
    import lmfw_pkg::*;
(
    input  logic                  i_use_emit,
    input  logic [FRAME_COLS-1:0] i_row,
    input  logic [7:0]            i_glyph_byte,
    input  logic [5:0]            i_amt,
    output logic [FRAME_COLS-1:0] o_row,
    output logic [7:0]            o_byte
);

    logic [FRAME_COLS-1:0] operand;
    logic [FRAME_COLS-1:0] shifted;

    // For an emit the wanted byte is shifted up into the top byte lane.
    assign operand = i_use_emit ? i_row
                                : {{(FRAME_COLS - 8){1'b0}}, rev8(i_glyph_byte)};
    assign shifted = operand << i_amt;
    assign o_row   = i_row | shifted;
    assign o_byte  = rotr1(rev8(shifted[FRAME_COLS-1 -: 8]));

endmodule

// ----- rtl/core/lmfw_ctrl.sv -----
// Sequencer that steps the shared row unit through print and emit requests.
module lmfw_ctrl
    import lmfw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_mode      i_mode,
    input  logic       i_glyph_ok,
    input  logic [5:0] i_x_pos,
    input  logic [3:0] i_y_pos,
    input  logic [3:0] i_digit,
    input  logic       i_out_free,
    output t_ctl       o_ctl
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [5:0] r_x;
    logic [3:0] r_y;
    logic [3:0] r_d;
    logic [4:0] tgt_row;
    logic [2:0] byte_idx;
    logic       digit_ok;
    logic       in_fire;

    // The input is ready exactly while the sequencer is idle.
    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign digit_ok = (i_digit >= DIGIT_MIN) && (i_digit <= DIGIT_MAX);
    assign tgt_row  = {1'b0, r_y} + {1'b0, r_cnt} - 5'd1;
    // Words 8..15 walk the lower row from its high byte down.
    assign byte_idx = r_cnt[3] ? ~r_cnt[2:0] : r_cnt[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_x_pos;
            r_y <= i_y_pos;
            r_d <= i_digit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                n_cnt       = '0;
                if (in_fire) begin
                    if (i_mode == MODE_PRINT && i_glyph_ok) begin
                        n_state = ST_PRINT;
                    end else if (i_mode == MODE_EMIT && digit_ok) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_PRINT: begin
                // Font row cnt is read now; the row read last step is merged.
                o_ctl.font_row  = r_cnt[2:0];
                o_ctl.row_sel   = tgt_row[3:0];
                o_ctl.shift_amt = r_x;
                o_ctl.print_we  = (r_cnt != '0) && !tgt_row[4];
                if (r_cnt == LAST_PRINT_STEP) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_EMIT: begin
                o_ctl.use_emit  = 1'b1;
                o_ctl.row_sel   = r_cnt[3] ? (r_d - 4'd1) : (r_d + 4'd7);
                o_ctl.shift_amt = {~byte_idx, 3'b000};
                o_ctl.last      = (r_cnt == LAST_EMIT_WORD);
                o_ctl.emit_load = i_out_free;
                if (i_out_free) begin
                    if (r_cnt == LAST_EMIT_WORD) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- dv/led_matrix_frame_writer_unit_tb.sv -----
// Self-checking testbench for the LED matrix frame writer: font loads, prints, emits and clears.
`timescale 1ns / 100ps

module led_matrix_frame_writer_unit_tb;
    import lmfw_pkg::*;

    localparam int GLYPH_COUNT = 96;
    localparam int RANDOM_ITEMS = 125;
    localparam int MAX_IDLE = 12;
    localparam int TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        t_mode      mode;
        logic [7:0] code;
        logic [2:0] frow;
        logic [7:0] fbyte;
        logic [5:0] x;
        logic [3:0] y;
        logic [3:0] digit;
    } t_request;

    typedef struct packed {
        logic [3:0] reg_addr;
        logic [7:0] data_byte;
        logic       last;
    } t_spi_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lmfw_in_if  req_if ();
    lmfw_out_if word_if ();

    led_matrix_frame_writer_unit #(
        .GLYPHS(GLYPH_COUNT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (word_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copies of the frame and the font, plus bookkeeping of written rows.
    logic [63:0] frame_img [FRAME_ROWS];
    logic [7:0]  font_img [GLYPH_COUNT * 8];
    logic [7:0]  rows_loaded [GLYPH_COUNT];
    int          loaded_glyphs [$];
    t_spi_word   pending_words [$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          steady_mode = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] mirror_byte(input logic [7:0] b);
        logic [7:0] m;
        for (int k = 0; k < 8; k++) begin
            m[k] = b[7 - k];
        end
        return m;
    endfunction

    // The byte as it goes on the wire: mirrored, then rotated right by one.
    function automatic logic [7:0] wire_byte(input logic [7:0] b);
        logic [7:0] m;
        m = mirror_byte(b);
        return {m[0], m[7:1]};
    endfunction

    function automatic void predict_words(input t_request r);
        int          g;
        int          row;
        int          d;
        logic [63:0] bits;
        t_spi_word   w;
        case (r.mode)
            MODE_LOAD, MODE_PRINT: begin
                g = int'(r.code) - int'(FIRST_CODE);
                if (g >= 0 && g < GLYPH_COUNT) begin
                    if (r.mode == MODE_LOAD) begin
                        font_img[g * 8 + r.frow] = r.fbyte;
                        rows_loaded[g][r.frow] = 1'b1;
                        if (rows_loaded[g] == 8'hFF && !(g inside {loaded_glyphs})) begin
                            loaded_glyphs.push_back(g);
                        end
                    end else begin
                        for (int i = 0; i < 8; i++) begin
                            row = int'(r.y) + i;
                            if (row < FRAME_ROWS) begin
                                bits = {56'd0, mirror_byte(font_img[g * 8 + i])};
                                frame_img[row] = frame_img[row] | (bits << r.x);
                            end
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < FRAME_ROWS; i++) begin
                    frame_img[i] = '0;
                end
            end
            default: begin
                d = int'(r.digit);
                if (d >= 1 && d <= 8) begin
                    for (int i = 0; i < 16; i++) begin
                        w.reg_addr = r.digit;
                        if (i < 8) begin
                            w.data_byte = wire_byte(frame_img[d + 7][8 * i +: 8]);
                        end else begin
                            w.data_byte = wire_byte(frame_img[d - 1][8 * (15 - i) +: 8]);
                        end
                        w.last = (i == 15);
                        pending_words.push_back(w);
                    end
                end
            end
        endcase
    endfunction

    function automatic int draw_idle();
        return steady_mode ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Starts from a posedge step and returns at the edge that accepted the request.
    // Valid stays high after acceptance so a back-to-back request does not toggle it.
    task automatic send_request(input t_request r);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= r.mode;
        req_if.symbol_code <= r.code;
        req_if.font_row    <= r.frow;
        req_if.font_byte   <= r.fbyte;
        req_if.x_pos       <= r.x;
        req_if.y_pos       <= r.y;
        req_if.digit       <= r.digit;
        do @(posedge i_clk); while (!req_if.ready);
        predict_words(r);
    endtask

    // Fields the mode does not use are filled at random.
    function automatic t_request noisy_req(input t_mode m);
        t_request r;
        r.mode  = m;
        r.code  = 8'($urandom_range(0, 255));
        r.frow  = 3'($urandom_range(0, 7));
        r.fbyte = 8'($urandom_range(0, 255));
        r.x     = 6'($urandom_range(0, 63));
        r.y     = 4'($urandom_range(0, 15));
        r.digit = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic logic [7:0] outside_code();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(129, 255));
    endfunction

    task automatic load_row(input logic [7:0] code, input logic [2:0] row,
                            input logic [7:0] pattern);
        t_request r;
        r = noisy_req(MODE_LOAD);
        r.code  = code;
        r.frow  = row;
        r.fbyte = pattern;
        send_request(r);
    endtask

    task automatic load_glyph(input int g);
        for (int i = 0; i < 8; i++) begin
            load_row(8'(g + FIRST_CODE), 3'(i), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic print_glyph(input logic [7:0] code, input logic [5:0] x, input logic [3:0] y);
        t_request r;
        r = noisy_req(MODE_PRINT);
        r.code = code;
        r.x    = x;
        r.y    = y;
        send_request(r);
    endtask

    task automatic emit_digit(input logic [3:0] d);
        t_request r;
        r = noisy_req(MODE_EMIT);
        r.digit = d;
        send_request(r);
    endtask

    task automatic clear_frame();
        send_request(noisy_req(MODE_CLEAR));
    endtask

    // Holds the sender off until every pending word has been taken.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic test_font_load();
        logic [7:0] patterns [8];
        patterns = '{8'h01, 8'h80, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        for (int i = 0; i < 8; i++) begin
            load_row(FIRST_CODE, 3'(i), patterns[i]);
        end
        // Codes just outside the font must leave the store alone.
        load_row(8'd32, 3'd0, 8'hFF);
        load_row(8'd129, 3'd7, 8'hFF);
    endtask

    task automatic test_print_edges();
        print_glyph(FIRST_CODE, 6'd0, 4'd0);
        print_glyph(FIRST_CODE, 6'd63, 4'd8);
        // Rows past the bottom are dropped and bits past the top column are lost.
        print_glyph(FIRST_CODE, 6'd60, 4'd12);
        print_glyph(8'd32, 6'd5, 4'd3);
        print_glyph(8'd255, 6'd9, 4'd1);
    endtask

    task automatic test_emit_digits();
        emit_digit(DIGIT_MIN);
        emit_digit(DIGIT_MAX);
        emit_digit(4'd4);
        emit_digit(4'd0);
        emit_digit(4'd9);
        emit_digit(4'd15);
    endtask

    task automatic test_clear();
        wait_drained();
        clear_frame();
        emit_digit(DIGIT_MAX);
        emit_digit(DIGIT_MIN);
    endtask

    task automatic test_random_traffic();
        int       done_items;
        int       pick;
        int       g;
        t_request r;
        done_items = 0;
        load_glyph(GLYPH_COUNT - 1);
        done_items += 8;
        while (done_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 24) == 0) begin
                steady_mode = ~steady_mode;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                case ($urandom_range(0, 4))
                    0:       g = 0;
                    1:       g = GLYPH_COUNT - 1;
                    default: g = $urandom_range(0, GLYPH_COUNT - 1);
                endcase
                load_glyph(g);
                done_items += 8;
            end else if (pick < 20) begin
                g = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
                load_row(8'(g + FIRST_CODE), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
                done_items++;
            end else if (pick < 50) begin
                g = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
                print_glyph(8'(g + FIRST_CODE), 6'($urandom_range(0, 63)),
                            ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8)));
                done_items++;
            end else if (pick < 82) begin
                emit_digit(4'($urandom_range(1, 8)));
                done_items++;
            end else if (pick < 87) begin
                if ($urandom_range(0, 1) == 0) begin
                    wait_drained();
                end
                clear_frame();
                done_items++;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        r = noisy_req(MODE_LOAD);
                        r.code = outside_code();
                        send_request(r);
                    end
                    1: begin
                        r = noisy_req(MODE_PRINT);
                        r.code = outside_code();
                        send_request(r);
                    end
                    default: begin
                        emit_digit(($urandom_range(0, 1) == 0) ? 4'd0
                                                               : 4'($urandom_range(9, 15)));
                    end
                endcase
                done_items++;
            end
        end
        steady_mode = 1'b0;
    endtask

    // Word sink: stalls at random, then checks each accepted word against the oldest one due.
    initial begin
        int        stall;
        t_spi_word want;
        word_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                word_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            word_if.ready <= 1'b1;
            do @(posedge i_clk); while (word_if.valid !== 1'b1);
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word addr=%0d data=%02h last=%0b with none pending",
                                          word_if.reg_addr, word_if.data_byte, word_if.last));
            end else begin
                want = pending_words.pop_front();
                if (word_if.reg_addr !== want.reg_addr) begin
                    report_mismatch($sformatf("reg_addr %0d, wanted %0d",
                                              word_if.reg_addr, want.reg_addr));
                end
                if (word_if.data_byte !== want.data_byte) begin
                    report_mismatch($sformatf("data_byte %02h, wanted %02h (addr %0d)",
                                              word_if.data_byte, want.data_byte, want.reg_addr));
                end
                if (word_if.last !== want.last) begin
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              word_if.last, want.last));
                end
            end
        end
    end

    initial begin
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_LOAD;
        req_if.symbol_code = '0;
        req_if.font_row    = '0;
        req_if.font_byte   = '0;
        req_if.x_pos       = '0;
        req_if.y_pos       = '0;
        req_if.digit       = '0;
        for (int i = 0; i < FRAME_ROWS; i++) begin
            frame_img[i] = '0;
        end
        for (int i = 0; i < GLYPH_COUNT * 8; i++) begin
            font_img[i] = '0;
        end
        for (int i = 0; i < GLYPH_COUNT; i++) begin
            rows_loaded[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_font_load();
        test_print_edges();
        test_emit_digits();
        test_clear();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
